/* sv/r2fft_pkg.sv */
// Package with the shared types and constants of the radix-2 FFT block.
package r2fft_pkg;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic REG_DIRECTION = 1'b0;
  localparam logic REG_LOG2_PTS  = 1'b1;

  localparam logic [3:0] LOG2_PTS_RESET = 4'd10;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         index;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         bin_index;
    logic signed [31:0] bin_re;
    logic signed [31:0] bin_im;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ,
    S_BR_RI, S_BR_RR, S_BR_W1, S_BR_W2,
    S_BF_A, S_BF_B, S_BF_C, S_BF_D, S_BF_E, S_BF_F, S_BF_G, S_BF_WJ, S_BF_WA
  } state_e;

endpackage

/* sv/r2fft_if.sv */
// Valid-ready channel interfaces for input items and result items.
interface r2fft_in_if import r2fft_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface r2fft_out_if import r2fft_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/radix2_complex_fft.sv */
// Iterative in-place radix-2 decimation-in-time FFT with one shared multiplier.
// A sample write is stored on acceptance; a bin read goes via the store read and output registers.
// A transform walks every index, swapping bit-reversed pairs by two reads and two writes; it then
// runs (N/2)*log2(N) butterflies through states S_BF_A to S_BF_WA, paced by the single multiplier
// and the single port of the sample store. The block takes no transaction meanwhile.
// Reset (asynchronous, active low) clears control state and config registers, not the store.
module radix2_complex_fft import r2fft_pkg::*; #(
  parameter int MAX_POINTS   = 1024,
  parameter int TWIDDLE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [3:0]        cfg_data_i,
  r2fft_in_if.sink          in_i,
  r2fft_out_if.source       out_o
);

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int LGW  = $clog2(AW + 1);
  localparam int PW   = AW + 2;
  localparam int FR   = TWIDDLE_BITS - 1;
  localparam int MW   = 32 + TWIDDLE_BITS + 1;
  localparam int ACW  = MW + 1;
  localparam int SW   = ACW + 1;

  typedef logic [TWIDDLE_BITS-1:0] rom_t [MAX_POINTS+1];

  // Shift-and-subtract division used while the table is built; the numerators of the
  // series terms stay well below 2^40.
  function automatic logic [63:0] udiv(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo, rem;
    quo = '0;
    rem = '0;
    for (int b = 39; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine table, worked out at elaboration by a truncated Taylor series in Q30.
  function automatic rom_t build_rom();
    rom_t r;
    logic [63:0] x, t;
    logic signed [63:0] s;
    for (int k = 0; k <= MAX_POINTS; k++) begin
      x = (64'(k) * PI_Q30 + 64'(MAX_POINTS)) >> (AW + 1);
      t = x;
      s = $signed(x);
      for (int i = 1; i < 40; i++) begin
        if (t != 64'd0) begin
          t = (t * x) >> 30;
          t = (t * x) >> 30;
          t = udiv(t, 64'(2 * i) * 64'(2 * i + 1));
          if ((i & 1) == 1) s = s - $signed(t);
          else s = s + $signed(t);
        end
      end
      if (s < 0) s = 64'sd0;
      s = (s + (64'sd1 <<< (29 - FR))) >>> (30 - FR);
      if (s > (64'sd1 <<< FR)) s = 64'sd1 <<< FR;
      r[k] = TWIDDLE_BITS'(s);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  function automatic logic signed [31:0] sat32(logic signed [SW-1:0] v);
    if (v > SW'(64'sd2147483647)) return 32'sh7fffffff;
    if (v < -SW'(64'sd2147483648)) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [SW-1:0] rnd(logic signed [ACW-1:0] v);
    logic signed [ACW:0] a;
    a = {v[ACW-1], v} + ((ACW+1)'(1) <<< (FR - 1));
    return SW'(a >>> FR);
  endfunction

  // Configuration registers.
  logic       dir_q;
  logic [3:0] lgp_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
      lgp_q <= LOG2_PTS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DIRECTION: dir_q <= cfg_data_i[0];
        REG_LOG2_PTS:  lgp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A point count above the store size acts as the store size.
  logic [LGW-1:0] lg;
  logic [AW-1:0]  n_m1, half_m1, idx_w;
  assign lg      = (32'(lgp_q) > AW) ? LGW'(AW) : LGW'(lgp_q);
  assign n_m1    = AW'((33'd1 << lg) - 33'd1);
  assign half_m1 = AW'(((33'd1 << lg) >> 1) - 33'd1);
  assign idx_w   = AW'(in_i.data.index) & n_m1;

  state_e state_q, state_d;
  logic [AW:0]    i_q;
  logic [AW-1:0]  b_q;
  logic [LGW-1:0] stg_q;
  logic [AW-1:0]  rd_idx_q;
  logic [63:0]    tmp_q, xj_q, ua_q;
  logic signed [TWIDDLE_BITS:0] s_q, c_q;
  logic signed [MW-1:0]  p_q;
  logic signed [ACW-1:0] tr_q, ti_q;
  logic           out_valid_q;
  out_item_t      out_q;

  logic in_fire;
  assign in_i.ready = (state_q == S_IDLE) && !out_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Loop positions: bit-reversed partner, and butterfly pair with its twiddle angle.
  logic [AW-1:0] i_lo, rev_full, rev_i, h_m1, q_w, a_w, j_w;
  logic          last_i, br_swap;
  logic [PW-1:0] p_s, p_c;
  assign i_lo = i_q[AW-1:0];
  always_comb begin
    for (int k = 0; k < AW; k++) rev_full[k] = i_lo[AW-1-k];
  end
  assign rev_i   = rev_full >> (AW - 32'(lg));
  assign br_swap = rev_i > i_lo;
  assign last_i  = (i_lo == n_m1);
  assign h_m1    = AW'((33'd1 << stg_q) - 33'd1);
  assign q_w     = b_q & h_m1;
  assign a_w     = AW'(((b_q >> stg_q) << (stg_q + 1'b1)) | q_w);
  assign j_w     = a_w | (h_m1 + 1'b1);
  assign p_s     = PW'(q_w) << (AW + 1 - 32'(stg_q));
  assign p_c     = p_s + PW'(MAX_POINTS);

  logic [AW:0] rom_addr;
  logic [TWIDDLE_BITS-1:0] rom_q;
  logic [PW-1:0] p_sel;
  assign p_sel    = (state_q == S_BF_A) ? p_s : p_c;
  assign rom_addr = p_sel[AW] ? ((AW+1)'(MAX_POINTS) - {1'b0, p_sel[AW-1:0]})
                              : {1'b0, p_sel[AW-1:0]};

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_i.data.kind)
            KIND_READ: state_d = S_READ;
            KIND_RUN:  state_d = S_BR_RI;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_READ:  state_d = S_IDLE;
      S_BR_RI: begin
        if (br_swap) state_d = S_BR_RR;
        else if (last_i) state_d = (lg == '0) ? S_IDLE : S_BF_A;
      end
      S_BR_RR: state_d = S_BR_W1;
      S_BR_W1: state_d = S_BR_W2;
      S_BR_W2: state_d = last_i ? ((lg == '0) ? S_IDLE : S_BF_A) : S_BR_RI;
      S_BF_A:  state_d = S_BF_B;
      S_BF_B:  state_d = S_BF_C;
      S_BF_C:  state_d = S_BF_D;
      S_BF_D:  state_d = S_BF_E;
      S_BF_E:  state_d = S_BF_F;
      S_BF_F:  state_d = S_BF_G;
      S_BF_G:  state_d = S_BF_WJ;
      S_BF_WJ: state_d = S_BF_WA;
      S_BF_WA: begin
        if (b_q == half_m1 && stg_q == lg - 1'b1) state_d = S_IDLE;
        else state_d = S_BF_A;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Store port and multiplier operand selection.
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [63:0]   mem_wdata, rd_q;
  logic signed [TWIDDLE_BITS:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [SW-1:0] ur, ui, trr, tir;
  assign ur  = SW'($signed(ua_q[63:32]));
  assign ui  = SW'($signed(ua_q[31:0]));
  assign trr = rnd(tr_q);
  assign tir = rnd(ti_q);

  always_comb begin
    mem_addr  = idx_w;
    mem_we    = 1'b0;
    mem_wdata = {32'(in_i.data.sample_re), 32'(in_i.data.sample_im)};
    mul_a     = s_q;
    mul_b     = $signed(xj_q[31:0]);
    case (state_q)
      S_IDLE:  mem_we = in_fire && (in_i.data.kind == KIND_WRITE);
      S_BR_RI: mem_addr = i_lo;
      S_BR_RR: mem_addr = rev_i;
      S_BR_W1: begin
        mem_addr = i_lo; mem_we = 1'b1; mem_wdata = rd_q;
      end
      S_BR_W2: begin
        mem_addr = rev_i; mem_we = 1'b1; mem_wdata = tmp_q;
      end
      S_BF_A:  mem_addr = j_w;
      S_BF_B:  mem_addr = a_w;
      S_BF_D:  mul_b = $signed(xj_q[63:32]);
      S_BF_E: begin
        mul_a = c_q; mul_b = $signed(xj_q[63:32]);
      end
      S_BF_F:  mul_a = c_q;
      S_BF_WJ: begin
        mem_addr = j_w; mem_we = 1'b1;
        mem_wdata = {sat32(ur - trr), sat32(ui - tir)};
      end
      S_BF_WA: begin
        mem_addr = a_w; mem_we = 1'b1;
        mem_wdata = {sat32(ur + trr), sat32(ui + tir)};
      end
      default: ;
    endcase
  end

  // Sample store: real part in the upper half of a word, imaginary part in the lower.
  logic [63:0] mem_q [MAX_POINTS];
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    rd_q  <= mem_q[mem_addr];
    rom_q <= SINE_ROM[rom_addr];
  end

  logic signed [TWIDDLE_BITS:0] rom_s;
  assign rom_s = $signed({1'b0, rom_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      b_q         <= '0;
      stg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          i_q   <= '0;
          b_q   <= '0;
          stg_q <= '0;
        end
        S_READ:  out_valid_q <= 1'b1;
        S_BR_RI: if (!br_swap) i_q <= i_q + 1'b1;
        S_BR_W2: i_q <= i_q + 1'b1;
        S_BF_WA: begin
          if (b_q == half_m1) begin
            b_q   <= '0;
            stg_q <= stg_q + 1'b1;
          end else begin
            b_q <= b_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers; the sine sign follows the quadrant and the direction.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE:  rd_idx_q <= idx_w;
      S_READ:  out_q <= '{bin_index: 10'(rd_idx_q), bin_re: rd_q[63:32], bin_im: rd_q[31:0]};
      S_BR_RR: tmp_q <= rd_q;
      S_BF_B: begin
        xj_q <= rd_q;
        s_q  <= (p_s[AW+1] ^ dir_q) ? -rom_s : rom_s;
      end
      S_BF_C: begin
        ua_q <= rd_q;
        c_q  <= p_c[AW+1] ? -rom_s : rom_s;
        p_q  <= mul_a * mul_b;
      end
      S_BF_D: begin
        p_q  <= mul_a * mul_b;
        tr_q <= -ACW'(p_q);
      end
      S_BF_E: begin
        p_q  <= mul_a * mul_b;
        ti_q <= ACW'(p_q);
      end
      S_BF_F: begin
        p_q  <= mul_a * mul_b;
        tr_q <= tr_q + ACW'(p_q);
      end
      S_BF_G:  ti_q <= ti_q + ACW'(p_q);
      default: ;
    endcase
  end

endmodule

/* tb/r2fft_checker.sv */
// Checker that predicts the FFT block from observed transactions and compares its results.
module r2fft_checker import r2fft_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  r2fft_in_if        in_mon,
  r2fft_out_if       out_mon,
  output int         fail_count_o,
  output int         pending_o,
  output int         bins_checked_o,
  output int         transforms_o
);

  localparam int NPTS  = 1024;
  localparam int FRAC  = 15;

  logic signed [31:0] re_mem [NPTS];
  logic signed [31:0] im_mem [NPTS];
  longint             sine_tab [NPTS + 1];
  logic               inverse;
  logic [3:0]         lg_reg;
  out_item_t          expected_bins [$];

  // Quarter-wave sine table in Q15, built by a Taylor series in Q30.
  initial begin
    longint unsigned x, t;
    longint          s;
    for (int k = 0; k <= NPTS; k++) begin
      x = (longint'(k) * PI_Q30 + NPTS) / (2 * NPTS);
      t = x;
      s = x;
      for (int i = 1; t != 0 && i < 40; i++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / (longint'(2 * i) * longint'(2 * i + 1));
        if (i % 2 == 1) s = s - longint'(t);
        else s = s + longint'(t);
      end
      if (s < 0) s = 0;
      s = (s + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
      if (s > (64'sd1 <<< FRAC)) s = 64'sd1 <<< FRAC;
      sine_tab[k] = s;
    end
  end

  function automatic longint sine_of(longint unsigned p);
    longint unsigned q, r;
    p = p % (4 * NPTS);
    q = p / NPTS;
    r = p % NPTS;
    case (q)
      0: return sine_tab[r];
      1: return sine_tab[NPTS - r];
      2: return -sine_tab[r];
      default: return -sine_tab[NPTS - r];
    endcase
  endfunction

  function automatic int lg_used();
    return (lg_reg > 4'd10) ? 10 : int'(lg_reg);
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Rounds to nearest at FRAC bits, ties towards plus infinity.
  function automatic longint round_q15(longint v);
    return (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  task automatic apply_transform();
    int lg, n, r, a, j, stride;
    longint c, s, xr, xi, tr, ti, ur, ui;
    logic signed [31:0] tmp;
    lg = lg_used();
    n  = 1 << lg;
    for (int i = 0; i < n; i++) begin
      r = 0;
      for (int b = 0; b < lg; b++) r |= ((i >> b) & 1) << (lg - 1 - b);
      if (r > i) begin
        tmp = re_mem[i]; re_mem[i] = re_mem[r]; re_mem[r] = tmp;
        tmp = im_mem[i]; im_mem[i] = im_mem[r]; im_mem[r] = tmp;
      end
    end
    for (int h = 1; h < n; h = h * 2) begin
      stride = NPTS / (2 * h);
      for (int q = 0; q < h; q++) begin
        c = sine_of(4 * longint'(q) * stride + NPTS);
        s = sine_of(4 * longint'(q) * stride);
        if (inverse) s = -s;
        for (a = q; a < n; a += 2 * h) begin
          j  = a + h;
          xr = re_mem[j];
          xi = im_mem[j];
          tr = round_q15(c * xr - s * xi);
          ti = round_q15(c * xi + s * xr);
          ur = re_mem[a];
          ui = im_mem[a];
          re_mem[j] = clip32(ur - tr);
          im_mem[j] = clip32(ui - ti);
          re_mem[a] = clip32(ur + tr);
          im_mem[a] = clip32(ui + ti);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    in_item_t  it;
    out_item_t got, want;
    int        idx;
    int        errs;
    if (!rst_ni) begin
      inverse        <= 1'b0;
      lg_reg         <= LOG2_PTS_RESET;
      fail_count_o   <= 0;
      pending_o      <= 0;
      bins_checked_o <= 0;
      transforms_o   <= 0;
    end else begin
      errs = 0;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_DIRECTION) inverse <= cfg_data_i[0];
        else lg_reg <= cfg_data_i;
      end
      if (in_mon.valid && in_mon.ready) begin
        it  = in_mon.data;
        idx = int'(it.index) & ((1 << lg_used()) - 1);
        case (it.kind)
          KIND_WRITE: begin
            re_mem[idx] = 32'(it.sample_re);
            im_mem[idx] = 32'(it.sample_im);
          end
          KIND_RUN: begin
            apply_transform();
            transforms_o <= transforms_o + 1;
          end
          KIND_READ: begin
            want.bin_index = 10'(idx);
            want.bin_re    = re_mem[idx];
            want.bin_im    = im_mem[idx];
            expected_bins.push_back(want);
          end
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (expected_bins.size() == 0) begin
          $error("unexpected bin %0d read back", got.bin_index);
          errs++;
        end else begin
          want = expected_bins.pop_front();
          bins_checked_o <= bins_checked_o + 1;
          if (got.bin_index !== want.bin_index) begin
            $error("bin_index: expected %0d, got %0d", want.bin_index, got.bin_index);
            errs++;
          end
          if (got.bin_re !== want.bin_re) begin
            $error("bin_re: expected %0d, got %0d", want.bin_re, got.bin_re);
            errs++;
          end
          if (got.bin_im !== want.bin_im) begin
            $error("bin_im: expected %0d, got %0d", want.bin_im, got.bin_im);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= expected_bins.size();
    end
  end

endmodule

/* tb/tb.sv */
// Top of the FFT testbench: clock, reset, stimulus, back-pressure and the verdict.
module tb import r2fft_pkg::*;;

  // Generous ceiling on the run: a handful of full-size transforms, plus several
  // hundred small transactions with heavy stalls.
  localparam int CYCLE_LIMIT = 3000000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [3:0] cfg_data_i;

  int fail_count, pending, bins_checked, transforms;
  int sent_count;
  int tx_idle_pct, rx_idle_pct;
  int hold_requests;
  int cycles;

  r2fft_in_if  in_if ();
  r2fft_out_if out_if ();

  radix2_complex_fft dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  r2fft_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .bins_checked_o (bins_checked),
    .transforms_o   (transforms)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // The watchdog counts clock cycles and abandons the run once the ceiling is passed.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run abandoned after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // The result side stalls at random. When the stimulus asks for a long
  // hold-off, this process counts it down itself, so that the block fills up
  // and has to refuse further input transactions.
  always @(negedge clk_i) begin
    int hold_left;
    int hold_seen;
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offers one transaction from a falling edge and returns at the falling edge
  // after it was accepted. The valid line is written at most once per edge, so
  // back-to-back transactions keep it high without a glitch.
  task automatic send(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic send_op(input logic [1:0] kind, input int idx, input int re, input int im);
    in_item_t it;
    it.kind      = kind;
    it.index     = 10'(idx);
    it.sample_re = 16'(re);
    it.sample_im = 16'(im);
    send(it);
  endtask

  // Registers may only change while the block is idle. Every phase ends with a
  // read, which the block cannot accept before a transform has finished, so an
  // empty expectation queue means that nothing is in flight any more.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic int pick_sample();
    case ($urandom_range(7))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return $urandom_range(65535);
    endcase
  endfunction

  // Random traffic shaped like real use: sample writes, the odd
  // transform, reads of bins, plus a sprinkle of unknown-kind noise. The chance
  // of a transform is kept low at full size, where each one is expensive.
  task automatic random_phase(input int count, input int lg);
    int roll;
    int run_pct;
    run_pct = (lg >= 10) ? 4 : 10;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 40) begin
        send_op(KIND_WRITE, $urandom_range(1023), pick_sample(), pick_sample());
      end else if (roll < 40 + run_pct) begin
        send_op(KIND_RUN, $urandom_range(1023), $urandom_range(65535), $urandom_range(65535));
      end else if (roll < 95) begin
        send_op(KIND_READ, $urandom_range(1023), $urandom_range(65535), $urandom_range(65535));
      end else begin
        send_op(2'd3, $urandom_range(1023), $urandom_range(65535), $urandom_range(65535));
      end
    end
    send_op(KIND_READ, $urandom_range(1023), 0, 0);
  endtask

  initial begin
    int dirs [9];
    int lgs  [9];
    int cnts [9];
    sent_count    = 0;
    hold_requests = 0;
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_DIRECTION;
    cfg_data_i    = '0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part at full size, forward. The whole store is filled first with
    // one constant extreme sample, so that no transform or read ever touches an
    // entry that was never written. Three transforms of that constant push the
    // DC bin past the 32-bit range and so exercise saturation.
    for (int k = 0; k < 1024; k++) send_op(KIND_WRITE, k, 32767, -32768);
    send_op(KIND_RUN, 0, 0, 0);
    send_op(KIND_READ, 0, 0, 0);
    send_op(KIND_READ, 1, 0, 0);
    send_op(KIND_RUN, 0, 0, 0);
    send_op(KIND_READ, 512, 0, 0);
    send_op(KIND_RUN, 0, 0, 0);
    send_op(KIND_READ, 0, 0, 0);
    send_op(KIND_READ, 1023, 0, 0);
    // Extreme samples at the ends of the index range, then read them back.
    send_op(KIND_WRITE, 0, -32768, 32767);
    send_op(KIND_WRITE, 1023, 32767, -32768);
    send_op(KIND_WRITE, 1, 0, 0);
    send_op(KIND_READ, 1023, 0, 0);
    send_op(KIND_READ, 0, 0, 0);
    // An unknown kind must be ignored and give no result.
    send_op(2'd3, 1, 1234, -1234);
    send_op(KIND_READ, 1, 0, 0);
    settle();

    // A two-point inverse transform, with index wrapping on write and read.
    write_reg(REG_DIRECTION, 4'd1);
    write_reg(REG_LOG2_PTS, 4'd1);
    send_op(KIND_WRITE, 1022, 1000, -3000);
    send_op(KIND_WRITE, 1023, -7, 32767);
    send_op(KIND_RUN, 0, 0, 0);
    send_op(KIND_READ, 1022, 0, 0);
    send_op(KIND_READ, 3, 0, 0);
    settle();

    // Random phases: three idling regimes, three register settings each,
    // including the size limit, an out-of-range size and the smallest size.
    dirs = '{1, 0, 1, 0, 1, 0, 1, 0, 1};
    lgs  = '{1, 2, 4, 3, 6, 5, 7, 10, 15};
    cnts = '{30, 30, 30, 30, 30, 30, 30, 15, 15};
    for (int p = 0; p < 9; p++) begin
      if (p < 3) begin
        tx_idle_pct = 19;
        rx_idle_pct = 55;
      end else if (p < 6) begin
        tx_idle_pct = 55;
        rx_idle_pct = 19;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_reg(REG_DIRECTION, 4'(dirs[p]));
      write_reg(REG_LOG2_PTS, 4'(lgs[p]));
      // Refresh the start of the active region with new data.
      for (int k = 0; k < (1 << ((lgs[p] > 10) ? 10 : lgs[p])) && k < 8; k++)
        send_op(KIND_WRITE, k, pick_sample(), pick_sample());
      if (p == 6) begin
        // Long stall on the result side while reads keep coming.
        hold_requests++;
        for (int k = 0; k < 20; k++) send_op(KIND_READ, $urandom_range(1023), 0, 0);
      end
      random_phase(cnts[p], lgs[p]);
      settle();
    end

    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Sent %0d input transactions, ran %0d transforms, checked %0d bins.",
             sent_count, transforms, bins_checked);
    $display("Covered both directions, sizes from 2 to 1024 points, and stalls on both sides.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
sv/r2fft_pkg.sv
sv/r2fft_if.sv
sv/radix2_complex_fft.sv
tb/r2fft_checker.sv
tb/tb.sv
